FILE: sv/dnf_pkg.sv
package dnf_pkg;

  // Field widths of the item, result and configuration beats.
  localparam int CMD_W      = 2;
  localparam int LAYER_W    = 2;
  localparam int NODE_W     = 4;
  localparam int VALUE_W    = 16;
  localparam int ACT_W      = 15;
  localparam int SIZE_W     = 5;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // Product of two Q8.8 values and the sum of up to sixteen of them.
  localparam int PROD_W = 32;
  localparam int ACC_W  = 36;

  // Number of entries in the size table: input plus up to four layers.
  localparam int SIZE_SLOTS = 5;

  // Item commands.
  localparam logic [CMD_W-1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BIAS    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FEATURE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RUN     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_HIDDEN_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_HIDDEN_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_HIDDEN_THREE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_OUT          = 3'd5;

  localparam logic [COUNT_W-1:0] RESET_LAYERS = 3'd2;
  localparam logic [SIZE_W-1:0]  RESET_SIZE   = 5'd2;

  // Largest activation after saturation.
  localparam logic [ACT_W-1:0] ACT_MAX = 15'h7fff;

  // Network shape after clamping: layer count and node count of every stage.
  typedef struct packed {
    logic [COUNT_W-1:0]                     layers;
    logic [SIZE_SLOTS-1:0][SIZE_W-1:0]      size;
  } shape_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;
    logic               issue;
    logic               first;
    logic               last;
    logic [LAYER_W-1:0] layer;
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  node;
    logic               from_feat;
    logic               wr_sel;
    logic               rd_sel;
    logic               out_load;
    logic               out_last;
  } dp_cmd_t;

endpackage

FILE: sv/dnf_if.sv
// Item channel: loads and run requests.
interface dnf_item_if;
  import dnf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [LAYER_W-1:0]        layer_sel;
  logic [NODE_W-1:0]         source_node;
  logic [NODE_W-1:0]         dest_node;
  logic signed [VALUE_W-1:0] load_value;

  modport source (output valid, command, layer_sel, source_node, dest_node, load_value,
                  input ready);
  modport sink (input valid, command, layer_sel, source_node, dest_node, load_value,
                output ready);
endinterface

// Result channel: one beat per output node.
interface dnf_result_if;
  import dnf_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_index;
  logic [ACT_W-1:0]  activation;
  logic              last;

  modport source (output valid, node_index, activation, last, input ready);
  modport sink (input valid, node_index, activation, last, output ready);
endinterface

// Configuration write channel.
interface dnf_cfg_if;
  import dnf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/dnf_cfg.sv
module dnf_cfg #(
  parameter int MAX_NODES         = 16,
  parameter int MAX_WEIGHT_LAYERS = 4
) (
  input  logic            clk,
  input  logic            rst,
  dnf_cfg_if.sink         cfg,
  output dnf_pkg::shape_t shape
);
  import dnf_pkg::*;

  localparam int NODE_CAP  = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int LAYER_CAP = (MAX_WEIGHT_LAYERS < 4) ? MAX_WEIGHT_LAYERS : 4;
  localparam logic [SIZE_W-1:0]  SIZE_CAP  = SIZE_W'(NODE_CAP);
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(LAYER_CAP);

  logic [COUNT_W-1:0] layer_count;
  logic [SIZE_W-1:0]  size_in;
  logic [SIZE_W-1:0]  size_hidden_one;
  logic [SIZE_W-1:0]  size_hidden_two;
  logic [SIZE_W-1:0]  size_hidden_three;
  logic [SIZE_W-1:0]  size_out;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_CAP) begin
      r = SIZE_CAP;
    end
    return r;
  endfunction

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count       <= RESET_LAYERS;
      size_in           <= RESET_SIZE;
      size_hidden_one   <= RESET_SIZE;
      size_hidden_two   <= RESET_SIZE;
      size_hidden_three <= RESET_SIZE;
      size_out          <= RESET_SIZE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LAYER_COUNT:       layer_count       <= cfg.data[COUNT_W-1:0];
        REG_SIZE_IN:           size_in           <= cfg.data;
        REG_SIZE_HIDDEN_ONE:   size_hidden_one   <= cfg.data;
        REG_SIZE_HIDDEN_TWO:   size_hidden_two   <= cfg.data;
        REG_SIZE_HIDDEN_THREE: size_hidden_three <= cfg.data;
        REG_SIZE_OUT:          size_out          <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamped shape; the output size takes the slot right after the last hidden layer.
  always_comb begin
    logic [COUNT_W-1:0] lay;
    lay = layer_count;
    if (layer_count == '0) begin
      lay = COUNT_W'(1);
    end else if (layer_count > COUNT_CAP) begin
      lay = COUNT_CAP;
    end
    shape.layers    = lay;
    shape.size[0]   = clamp_size(size_in);
    shape.size[1]   = clamp_size(size_hidden_one);
    shape.size[2]   = clamp_size(size_hidden_two);
    shape.size[3]   = clamp_size(size_hidden_three);
    shape.size[4]   = clamp_size(size_out);
    shape.size[lay] = clamp_size(size_out);
  end

endmodule

FILE: sv/dnf_ctrl.sv
module dnf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  dnf_pkg::shape_t           shape,
  input  logic                      item_valid,
  input  logic [dnf_pkg::CMD_W-1:0] item_command,
  output logic                      item_ready,
  output logic                      result_valid,
  input  logic                      result_ready,
  output dnf_pkg::dp_cmd_t          cmd
);
  import dnf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // Cycles from the last issue of a layer until its last result is in the buffer.
  localparam int DRAIN_CYCLES = 4;
  localparam int DC_W = $clog2(DRAIN_CYCLES);

  logic [1:0]         state;
  logic [LAYER_W-1:0] layer;
  logic [SIZE_W-1:0]  node_cnt;
  logic [SIZE_W-1:0]  src_cnt;
  logic [SIZE_W-1:0]  out_cnt;
  logic [DC_W-1:0]    drain_cnt;
  logic               out_valid;

  logic [SIZE_W-1:0]  in_size;
  logic [SIZE_W-1:0]  out_size;
  logic               last_src;
  logic               last_node;
  logic               last_out;
  logic               last_layer;
  logic               emit_go;

  // Sizes of the layer at work.
  assign in_size    = shape.size[COUNT_W'(layer)];
  assign out_size   = shape.size[COUNT_W'(layer) + COUNT_W'(1)];
  assign last_src   = (src_cnt == in_size - SIZE_W'(1));
  assign last_node  = (node_cnt == out_size - SIZE_W'(1));
  assign last_out   = (out_cnt == out_size - SIZE_W'(1));
  assign last_layer = (COUNT_W'(layer) + COUNT_W'(1) == shape.layers);
  assign emit_go    = (state == S_EMIT) && (!out_valid || result_ready);

  assign item_ready   = (state == S_IDLE);
  assign result_valid = out_valid;

  // Command word to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && item_valid && (item_command != CMD_RUN);
    cmd.issue     = (state == S_CALC);
    cmd.first     = (src_cnt == '0);
    cmd.last      = last_src;
    cmd.layer     = layer;
    cmd.node      = node_cnt[NODE_W-1:0];
    cmd.wr_sel    = layer[0];
    cmd.out_load  = emit_go;
    cmd.out_last  = last_out;
    if (state == S_EMIT) begin
      cmd.src       = out_cnt[NODE_W-1:0];
      cmd.from_feat = 1'b0;
      cmd.rd_sel    = layer[0];
    end else begin
      cmd.src       = src_cnt[NODE_W-1:0];
      cmd.from_feat = (layer == '0);
      cmd.rd_sel    = ~layer[0];
    end
  end

  // Sequencer: layers, nodes, sources, then the output nodes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      layer     <= '0;
      node_cnt  <= '0;
      src_cnt   <= '0;
      out_cnt   <= '0;
      drain_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid && item_command == CMD_RUN) begin
            state    <= S_CALC;
            layer    <= '0;
            node_cnt <= '0;
            src_cnt  <= '0;
          end
        end
        S_CALC: begin
          if (last_src) begin
            src_cnt <= '0;
            if (last_node) begin
              node_cnt  <= '0;
              drain_cnt <= '0;
              state     <= S_DRAIN;
            end else begin
              node_cnt <= node_cnt + SIZE_W'(1);
            end
          end else begin
            src_cnt <= src_cnt + SIZE_W'(1);
          end
        end
        S_DRAIN: begin
          if (drain_cnt == DC_W'(DRAIN_CYCLES - 1)) begin
            if (last_layer) begin
              out_cnt <= '0;
              state   <= S_EMIT;
            end else begin
              layer <= layer + LAYER_W'(1);
              state <= S_CALC;
            end
          end else begin
            drain_cnt <= drain_cnt + DC_W'(1);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_cnt <= out_cnt + SIZE_W'(1);
            if (last_out) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/dnf_dp.sv
module dnf_dp #(
  parameter int MAX_NODES         = 16,
  parameter int MAX_WEIGHT_LAYERS = 4,
  parameter int FRAC_BITS         = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dnf_pkg::dp_cmd_t                   cmd,
  input  logic [dnf_pkg::CMD_W-1:0]          command,
  input  logic [dnf_pkg::LAYER_W-1:0]        layer_sel,
  input  logic [dnf_pkg::NODE_W-1:0]         source_node,
  input  logic [dnf_pkg::NODE_W-1:0]         dest_node,
  input  logic signed [dnf_pkg::VALUE_W-1:0] load_value,
  output logic [dnf_pkg::NODE_W-1:0]         node_index,
  output logic [dnf_pkg::ACT_W-1:0]          activation,
  output logic                               last
);
  import dnf_pkg::*;

  localparam int NODE_CAP  = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int LAYER_CAP = (MAX_WEIGHT_LAYERS < 4) ? MAX_WEIGHT_LAYERS : 4;
  localparam int NI_W      = $clog2(NODE_CAP);
  localparam int W_DEPTH   = LAYER_CAP * NODE_CAP * NODE_CAP;
  localparam int WA_W      = $clog2(W_DEPTH);
  localparam int B_DEPTH   = LAYER_CAP * NODE_CAP;
  localparam int BA_W      = $clog2(B_DEPTH);

  function automatic logic [WA_W-1:0] w_addr(input logic [LAYER_W-1:0] lay,
                                             input logic [NODE_W-1:0]  src,
                                             input logic [NODE_W-1:0]  dst);
    return WA_W'((int'(lay) * NODE_CAP + int'(src)) * NODE_CAP + int'(dst));
  endfunction

  function automatic logic [BA_W-1:0] b_addr(input logic [LAYER_W-1:0] lay,
                                             input logic [NODE_W-1:0]  dst);
    return BA_W'(int'(lay) * NODE_CAP + int'(dst));
  endfunction

  // Stores.
  logic signed [VALUE_W-1:0] wmem [W_DEPTH];
  logic signed [VALUE_W-1:0] bmem [B_DEPTH];
  logic [B_DEPTH-1:0]        bvalid;
  logic signed [VALUE_W-1:0] feat [NODE_CAP];
  logic [ACT_W-1:0]          lbuf [2][NODE_CAP];

  logic            lay_ok, src_ok, dst_ok;
  logic            w_we, b_we, f_we;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [BA_W-1:0] b_waddr, b_raddr;
  logic [NI_W-1:0] rd_idx;

  logic signed [VALUE_W-1:0] a_src;
  logic [ACT_W-1:0]          rd_act;

  // Pipeline registers.
  logic                      b_v, b_first, b_last, b_wsel;
  logic [NODE_W-1:0]         b_node;
  logic signed [VALUE_W-1:0] w_q, a_q, bias_rd;
  logic                      bias_vq;
  logic                      c_v, c_first, c_last, c_wsel;
  logic [NODE_W-1:0]         c_node;
  logic signed [PROD_W-1:0]  prod;
  logic signed [VALUE_W-1:0] c_bias;
  logic signed [ACC_W-1:0]   acc;
  logic                      d_fin, d_wsel;
  logic [NODE_W-1:0]         d_node;
  logic signed [VALUE_W-1:0] d_bias;

  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_shift;
  logic [ACC_W:0]            z;
  logic [ACT_W-1:0]          act;

  // Load decode; entries that a run can never reach are not kept.
  assign lay_ok  = (int'(layer_sel) < LAYER_CAP);
  assign src_ok  = (int'(source_node) < NODE_CAP);
  assign dst_ok  = (int'(dest_node) < NODE_CAP);
  assign w_we    = cmd.load && (command == CMD_WEIGHT) && lay_ok && src_ok && dst_ok;
  assign b_we    = cmd.load && (command == CMD_BIAS) && lay_ok && dst_ok;
  assign f_we    = cmd.load && (command == CMD_FEATURE) && src_ok;
  assign w_waddr = w_addr(layer_sel, source_node, dest_node);
  assign b_waddr = b_addr(layer_sel, dest_node);
  assign w_raddr = w_addr(cmd.layer, cmd.src, cmd.node);
  assign b_raddr = b_addr(cmd.layer, cmd.node);
  assign rd_idx  = cmd.src[NI_W-1:0];

  // Weight memory, one write and one registered read.
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= load_value;
    end
    w_q <= wmem[w_raddr];
  end

  // Bias memory; an entry never written reads as zero through its valid bit.
  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_waddr] <= load_value;
    end
    bias_rd <= bmem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
    end else if (b_we) begin
      bvalid[b_waddr] <= 1'b1;
    end
  end

  // Input features, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NODE_CAP; k++) begin
        feat[k] <= '0;
      end
    end else if (f_we) begin
      feat[source_node[NI_W-1:0]] <= load_value;
    end
  end

  // Source operand: features for the first layer, else the previous layer's buffer.
  assign rd_act = lbuf[cmd.rd_sel][rd_idx];
  assign a_src  = cmd.from_feat ? feat[rd_idx] : signed'({1'b0, rd_act});

  // Valid flags of the multiply-accumulate pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      d_fin <= 1'b0;
    end else begin
      b_v   <= cmd.issue;
      c_v   <= b_v;
      d_fin <= c_v && c_last;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // Operand fetch, multiply and accumulate.
  always_ff @(posedge clk) begin
    b_first <= cmd.first;
    b_last  <= cmd.last;
    b_node  <= cmd.node;
    b_wsel  <= cmd.wr_sel;
    a_q     <= a_src;
    bias_vq <= bvalid[b_raddr];

    c_first <= b_first;
    c_last  <= b_last;
    c_node  <= b_node;
    c_wsel  <= b_wsel;
    prod    <= w_q * a_q;
    c_bias  <= bias_vq ? bias_rd : '0;

    if (c_v) begin
      acc <= c_first ? prod_ext : acc + prod_ext;
    end
    if (c_v && c_last) begin
      d_bias <= c_bias;
      d_node <= c_node;
      d_wsel <= c_wsel;
    end
  end

  // Scale back to Q8.8, add the bias, then ReLU with saturation.
  always_comb begin
    acc_shift = acc >>> FRAC_BITS;
    z = {acc_shift[ACC_W-1], acc_shift} +
        {{(ACC_W + 1 - VALUE_W){d_bias[VALUE_W-1]}}, d_bias};
    if (z[ACC_W]) begin
      act = '0;
    end else if (z[ACC_W-1:0] > ACC_W'(ACT_MAX)) begin
      act = ACT_MAX;
    end else begin
      act = z[ACT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (d_fin) begin
      lbuf[d_wsel][d_node[NI_W-1:0]] <= act;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      node_index <= cmd.src;
      activation <= rd_act;
      last       <= cmd.out_last;
    end
  end

endmodule

FILE: sv/dense_relu_network_forward.sv
// Channel  Role   Beat                                        Handshake
// item     sink   command, layer_sel, source_node, dest_node,  valid/ready
//                 load_value
// result   source node_index, activation, last                 valid/ready
// cfg      sink   index, data                                  valid/ready (always ready)
//
// Loads can follow each other in every cycle. A run works through each layer
// on the single multiply-accumulate pipeline (one weight memory read per
// cycle), every input for each node in turn, and drains it, then the output
// nodes go out one by one while result is ready. A stalled result holds its
// beat; item is not ready while a run computes. Reset sets the config and
// control registers, clears the features and bias valid bits at once, with no
// clearing pass; weights hold nothing defined until loaded.
module dense_relu_network_forward #(
  parameter int MAX_NODES         = 16,
  parameter int MAX_WEIGHT_LAYERS = 4,
  parameter int FRAC_BITS         = 8
) (
  input logic          clk,
  input logic          rst,
  dnf_item_if.sink     item,
  dnf_result_if.source result,
  dnf_cfg_if.sink      cfg
);
  import dnf_pkg::*;

  shape_t  shape;
  dp_cmd_t cmd;

  // Configuration registers and shape clamping.
  dnf_cfg #(
    .MAX_NODES         (MAX_NODES),
    .MAX_WEIGHT_LAYERS (MAX_WEIGHT_LAYERS)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .shape (shape)
  );

  // Sequencer.
  dnf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .shape        (shape),
    .item_valid   (item.valid),
    .item_command (item.command),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd)
  );

  // Stores and arithmetic.
  dnf_dp #(
    .MAX_NODES         (MAX_NODES),
    .MAX_WEIGHT_LAYERS (MAX_WEIGHT_LAYERS),
    .FRAC_BITS         (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .command     (item.command),
    .layer_sel   (item.layer_sel),
    .source_node (item.source_node),
    .dest_node   (item.dest_node),
    .load_value  (item.load_value),
    .node_index  (result.node_index),
    .activation  (result.activation),
    .last        (result.last)
  );

endmodule

FILE: sv/dnf_checker.sv
module dnf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic [dnf_pkg::CMD_W-1:0] item_command,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [dnf_pkg::NODE_W-1:0] node_index,
  input logic [dnf_pkg::ACT_W-1:0] activation,
  input logic                      last
);
  import dnf_pkg::*;

  // No result is offered right after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A run beat makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_command == CMD_RUN) |=> !item_ready)
    else $error("item still ready after a run beat");

  // A load beat leaves the block ready for the next beat.
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_command != CMD_RUN) |=> item_ready)
    else $error("item not ready after a load beat");

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(node_index) && $stable(activation) && $stable(last)))
    else $error("stalled result beat changed");

endmodule

bind dense_relu_network_forward dnf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_command (item.command),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .node_index   (result.node_index),
  .activation   (result.activation),
  .last         (result.last)
);
